// File: rtl/spq_pkg.sv
package spq_pkg;

    localparam int SPQ_CAPACITY = 16;
    localparam int SPQ_DATA_W   = 32;
    localparam int SPQ_STATUS_W = 2;

    typedef enum logic [SPQ_STATUS_W-1:0] {
        ST_ENQ   = 2'd0,
        ST_DEQ   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_spq_status;

    typedef logic signed [SPQ_DATA_W-1:0] t_spq_word;

    // One slot of the sorted row.
    typedef struct packed {
        logic      valid;
        t_spq_word value;
        t_spq_word prio;
    } t_spq_entry;

    // Operation broadcast to every cell in the cycle a beat is taken.
    typedef struct packed {
        logic      enq;
        logic      deq;
        t_spq_word value;
        t_spq_word prio;
    } t_spq_op;

endpackage

// File: rtl/spq_in_if.sv
interface spq_in_if;
    import spq_pkg::*;

    logic      valid;
    logic      ready;
    logic      cmd;
    t_spq_word in_value;
    t_spq_word in_priority;

    modport source (output valid, output cmd, output in_value, output in_priority,
                    input ready);
    modport sink   (input valid, input cmd, input in_value, input in_priority,
                    output ready);
endinterface

// File: rtl/spq_out_if.sv
interface spq_out_if;
    import spq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [SPQ_STATUS_W-1:0] status;
    t_spq_word               out_value;
    t_spq_word               out_priority;

    modport source (output valid, output status, output out_value, output out_priority,
                    input ready);
    modport sink   (input valid, input status, input out_value, input out_priority,
                    output ready);
endinterface

// File: rtl/sorted_priority_queue.sv
// Sorted priority queue of CAPACITY entries built as a row of cells, each
// holding one value with its signed priority. Higher priorities sit nearer the
// head and equal priorities keep arrival order. Every cell compares its own
// priority with the incoming one at once, so an enqueue or a dequeue beat is
// taken in every cycle in which no result waits unaccepted, and its single
// result beat appears in the next cycle from an output register; the next
// beat is taken while that result waits, as long as the sink takes it in the
// same cycle. An enqueue on a full queue returns status full, a dequeue on an
// empty queue returns status empty, both leaving the contents unchanged.
module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    spq_in_if.sink   i_in,
    spq_out_if.source o_out
);
    import spq_pkg::*;

    t_spq_op                  op;
    t_spq_entry [CAPACITY-1:0] entries;
    logic       [CAPACITY-1:0] past;
    logic                     take;
    logic                     full;
    logic                     empty;

    logic                     r_out_valid;
    t_spq_status              r_status;
    t_spq_word                r_out_value;
    t_spq_word                r_out_prio;
    t_spq_status              n_status;

    assign full  = entries[CAPACITY-1].valid;
    assign empty = !entries[0].valid;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign take       = i_in.valid && i_in.ready;

    assign op.enq   = take && !i_in.cmd && !full;
    assign op.deq   = take && i_in.cmd && !empty;
    assign op.value = i_in.in_value;
    assign op.prio  = i_in.in_priority;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            t_spq_entry left;
            t_spq_entry right;
            logic       left_past;

            if (gi == 0) begin : g_head
                assign left      = '0;
                assign left_past = 1'b0;
            end else begin : g_mid
                assign left      = entries[gi-1];
                assign left_past = past[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                assign right = '0;
            end else begin : g_body
                assign right = entries[gi+1];
            end

            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_op        (op),
                .i_left      (left),
                .i_left_past (left_past),
                .i_right     (right),
                .o_entry     (entries[gi]),
                .o_past      (past[gi])
            );
        end
    endgenerate

    always_comb begin
        if (!i_in.cmd) begin
            n_status = full ? ST_FULL : ST_ENQ;
        end else begin
            n_status = empty ? ST_EMPTY : ST_DEQ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (take) begin
            r_status    <= n_status;
            r_out_value <= op.deq ? entries[0].value : '0;
            r_out_prio  <= op.deq ? entries[0].prio : '0;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_status;
    assign o_out.out_value    = r_out_value;
    assign o_out.out_priority = r_out_prio;
endmodule

// File: rtl/spq_cell.sv
module spq_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spq_pkg::t_spq_op    i_op,
    input  spq_pkg::t_spq_entry i_left,
    input  logic                i_left_past,
    input  spq_pkg::t_spq_entry i_right,
    output spq_pkg::t_spq_entry o_entry,
    output logic                o_past
);
    import spq_pkg::*;

    t_spq_entry r_entry;
    t_spq_entry n_entry;

    // A cell is at or beyond the insertion point when it is empty or holds a
    // strictly lower priority than the incoming entry. The row is sorted, so
    // this flag rises once along the chain and stays high.
    assign o_past  = !r_entry.valid || (r_entry.prio < i_op.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_op.enq && o_past) begin
            if (!i_left_past) begin
                n_entry.valid = 1'b1;
                n_entry.value = i_op.value;
                n_entry.prio  = i_op.prio;
            end else begin
                n_entry = i_left;
            end
        end else if (i_op.deq) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.value <= n_entry.value;
        r_entry.prio  <= n_entry.prio;
    end
endmodule

// File: dv/tb_sorted_priority_queue.sv
`timescale 1ns / 100ps

module tb_sorted_priority_queue;
    import spq_pkg::*;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;
    localparam int   N_RANDOM   = 500;
    localparam int   CYCLE_LIMIT = 100000;
    localparam int   IDLE_PCT   = 30;
    localparam int   HOLD_CYCLES = 60;

    typedef struct {
        logic      cmd;
        t_spq_word value;
        t_spq_word prio;
    } t_request;

    typedef struct {
        t_spq_status status;
        t_spq_word   value;
        t_spq_word   prio;
    } t_response;

    logic i_clk = 1'b0;
    logic i_rst_n;

    spq_in_if  in_if ();
    spq_out_if out_if ();

    sorted_priority_queue u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #10 i_clk = ~i_clk;

    t_request    pending_q[$];
    t_response   due_results[$];
    t_spq_word   row_prio[SPQ_CAPACITY];
    t_spq_word   row_value[SPQ_CAPACITY];
    int unsigned row_fill = 0;
    int unsigned cyc = 0;
    int unsigned errors = 0;
    int unsigned hold_left = 0;
    bit          in_beat_taken = 1'b0;
    logic        calm;

    // Both sides run without gaps inside this window.
    assign calm = (cyc >= 400) && (cyc < 700);

    // Applies one command to the mirrored row and returns the result beat it causes.
    function automatic t_response serve_command(t_request req);
        t_response   rsp;
        int unsigned slot;
        int unsigned i;
        rsp.status = ST_ENQ;
        rsp.value  = '0;
        rsp.prio   = '0;
        if (req.cmd == CMD_ENQ) begin
            if (row_fill >= SPQ_CAPACITY) begin
                rsp.status = ST_FULL;
            end else begin
                // New entry lands before the first strictly lower priority.
                slot = row_fill;
                for (i = 0; i < row_fill; i++) begin
                    if (row_prio[i] < req.prio) begin
                        slot = i;
                        break;
                    end
                end
                for (i = row_fill; i > slot; i--) begin
                    row_prio[i]  = row_prio[i-1];
                    row_value[i] = row_value[i-1];
                end
                row_prio[slot]  = req.prio;
                row_value[slot] = req.value;
                row_fill++;
            end
        end else begin
            if (row_fill == 0) begin
                rsp.status = ST_EMPTY;
            end else begin
                rsp.status = ST_DEQ;
                rsp.value  = row_value[0];
                rsp.prio   = row_prio[0];
                for (i = 1; i < row_fill; i++) begin
                    row_prio[i-1]  = row_prio[i];
                    row_value[i-1] = row_value[i];
                end
                row_fill--;
            end
        end
        return rsp;
    endfunction

    task automatic add_request(logic cmd, t_spq_word value, t_spq_word prio);
        t_request req;
        req.cmd   = cmd;
        req.value = value;
        req.prio  = prio;
        pending_q.push_back(req);
    endtask

    // Command driver: a beat stays on the bus until it is taken.
    always @(negedge i_clk) begin
        t_request req;
        logic     send;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_beat_taken) begin
            in_beat_taken = 1'b0;
            send = (pending_q.size() != 0) && (calm || $urandom_range(99) >= IDLE_PCT);
            if (send) begin
                req = pending_q.pop_front();
                in_if.valid       <= 1'b1;
                in_if.cmd         <= req.cmd;
                in_if.in_value    <= req.value;
                in_if.in_priority <= req.prio;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Result sink with random stalls and a periodic long hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_if.ready <= 1'b0;
        end else if (cyc % 800 == 300) begin
            hold_left = HOLD_CYCLES;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Checks result beats against the oldest due result, then predicts new command beats.
    always @(posedge i_clk) begin
        t_response want;
        t_request  req;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: result beat with nothing due: status %0d value %0d prio %0d",
                             $time, out_if.status, out_if.out_value, out_if.out_priority);
                    errors++;
                end else begin
                    want = due_results.pop_front();
                    if (out_if.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, out_if.status);
                        errors++;
                    end
                    if (out_if.out_value !== want.value) begin
                        $display("%0t: out_value expected %0d actual %0d",
                                 $time, want.value, out_if.out_value);
                        errors++;
                    end
                    if (out_if.out_priority !== want.prio) begin
                        $display("%0t: out_priority expected %0d actual %0d",
                                 $time, want.prio, out_if.out_priority);
                        errors++;
                    end
                end
            end
            if (in_if.valid && in_if.ready) begin
                req.cmd   = in_if.cmd;
                req.value = in_if.in_value;
                req.prio  = in_if.in_priority;
                due_results.push_back(serve_command(req));
                in_beat_taken = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        t_spq_word prio;
        logic      lean_enq;
        int        n;
        int        k;
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.cmd         = CMD_ENQ;
        in_if.in_value    = '0;
        in_if.in_priority = '0;
        out_if.ready      = 1'b0;
        lean_enq          = 1'b0;

        // Directed: empty dequeue, extremes and ties while filling, full enqueue, a few dequeues.
        add_request(CMD_DEQ, 32'h1234_5678, 32'h7fff_ffff);
        add_request(CMD_ENQ, 32'h7fff_ffff, 32'sd0);
        add_request(CMD_ENQ, 32'h8000_0000, 32'sd0);
        add_request(CMD_ENQ, 32'sd0, 32'h7fff_ffff);
        add_request(CMD_ENQ, -32'sd1, 32'h8000_0000);
        add_request(CMD_ENQ, 32'sd5, -32'sd1);
        add_request(CMD_ENQ, 32'sd6, 32'sd1);
        add_request(CMD_ENQ, 32'sd7, 32'h7fff_ffff);
        add_request(CMD_ENQ, 32'sd8, 32'h8000_0000);
        for (k = 0; k < 8; k++) begin
            add_request(CMD_ENQ, 32'sd100 + k, k - 4);
        end
        add_request(CMD_ENQ, 32'hffff_ffff, 32'h7fff_ffff);
        for (k = 0; k < 4; k++) begin
            add_request(CMD_DEQ, 32'h5555_aaaa, 32'haaaa_5555);
        end

        // Random: the mix swings between filling and draining so both ends are hit often.
        for (n = 0; n < N_RANDOM; n++) begin
            if (n % 48 == 0) begin
                lean_enq = ~lean_enq;
            end
            case ($urandom_range(3))
                0, 1: begin
                    prio = $urandom_range(8);
                    prio = prio - 4;
                end
                2: begin
                    case ($urandom_range(3))
                        0: prio = 32'h7fff_ffff;
                        1: prio = 32'h8000_0000;
                        2: prio = 32'sd0;
                        default: prio = -32'sd1;
                    endcase
                end
                default: prio = $urandom;
            endcase
            add_request(($urandom_range(99) < (lean_enq ? 25 : 75)) ? CMD_DEQ : CMD_ENQ,
                        $urandom, prio);
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_q.size() != 0 || in_if.valid) begin
            @(posedge i_clk);
        end
        while (due_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
